[rtl/core/ole_pkg.sv]
`default_nettype none
package ole_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_SEARCH   = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_VAL  = 3'd4
  } ole_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } ole_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } ole_state_t;

endpackage
`default_nettype wire

[rtl/core/ole_if.sv]
`default_nettype none
// request channel
interface ole_req_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::OP_W-1:0]         op;
  logic signed [ole_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// result channel; count width follows the list depth
interface ole_rsp_if #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
);
  localparam int CW = $clog2(DEPTH + 1);

  logic                              valid;
  logic                              ready;
  logic [ole_pkg::STAT_W-1:0]        status;
  logic                              found;
  logic signed [ole_pkg::DATA_W-1:0] data;
  logic [CW-1:0]                     count;

  modport source (output valid, output status, output found, output data, output count,
                  input ready);
  modport sink   (input valid, input status, input found, input data, input count,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/ole_ram.sv]
`default_nettype none
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/ordered_list_engine.sv]
`default_nettype none
// Insert, remove head and unused ops give the result from S_EXEC, the state after accept;
//   search and remove value first walk k entries in S_WALK (k <= count), then give it.
// Throughput: one transaction at a time, set by the one-read-per-cycle link walk;
//   the next request is taken the cycle after a result registers.
// Reset (sync, active low) clears control only; no clearing pass, the free stack
//   uses a low-water mark so never-written entries read as their reset index.
module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ole_req_if.sink   in_ch,
  ole_rsp_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);      // slot index width
  localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
  localparam int DW = ole_pkg::DATA_W;

  // control state
  ole_pkg::ole_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;     // element count
  logic [CW-1:0] ftop_r, ftop_nxt;   // free stack top (number of free slots)
  logic [CW-1:0] lw_r, lw_nxt;       // lowest free top ever seen since reset
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          out_valid_r;

  // per-transaction working registers
  ole_pkg::ole_op_t op_r, op_nxt;
  logic signed [DW-1:0] val_r, val_nxt;
  logic [AW-1:0] p_r, p_nxt;         // walk pointer
  logic [AW-1:0] prev_r, prev_nxt;   // element before p_r
  logic [CW-1:0] idx_r, idx_nxt;     // position of p_r in the list

  // result register
  ole_pkg::ole_status_t out_status_r;
  logic                 out_found_r;
  logic signed [DW-1:0] out_data_r;
  logic [CW-1:0]        out_count_r;

  // memory ports
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] v_rd;
  logic          v_we;
  logic [AW-1:0] v_waddr;
  logic [AW-1:0] l_rd;
  logic          l_we;
  logic [AW-1:0] l_waddr, l_wdata;
  logic [AW-1:0] f_rd;
  logic          f_we;

  // combinational results
  ole_pkg::ole_status_t res_status;
  logic                 res_found;
  logic signed [DW-1:0] res_data;
  logic                 done;
  logic                 out_free;
  logic [CW-1:0]        ftop_m1;
  logic [AW-1:0]        alloc_slot;
  logic                 walk_end;
  logic                 hit;

  // value and link stores share the walk read address
  ole_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (v_rd)
  );

  ole_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (rd_addr),
    .rdata (l_rd)
  );

  // free slot stack: pushed at ftop_r, read at ftop_r-1
  ole_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (ftop_r[AW-1:0]),
    .wdata (p_r),
    .raddr (ftop_m1[AW-1:0]),
    .rdata (f_rd)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign ftop_m1  = ftop_r - CW'(1);

  // Stack positions below the low-water mark were never pushed since reset,
  // so they still hold their reset index DEPTH-1-pos.
  assign alloc_slot = (ftop_m1 < lw_r) ? (AW'(DEPTH - 1) - ftop_m1[AW-1:0]) : f_rd;

  // walk: read data on v_rd/l_rd belongs to p_r
  assign walk_end = (idx_r == cnt_r);
  assign hit      = !walk_end && (v_rd == val_r);

  assign in_ch.ready = (state_r == ole_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    ftop_nxt   = ftop_r;
    lw_nxt     = lw_r;
    p_nxt      = p_r;
    prev_nxt   = prev_r;
    idx_nxt    = idx_r;
    rd_addr    = head_r;
    v_we       = 1'b0;
    v_waddr    = alloc_slot;
    l_we       = 1'b0;
    l_waddr    = alloc_slot;
    l_wdata    = head_r;
    f_we       = 1'b0;
    done       = 1'b0;
    res_status = ole_pkg::STAT_OK;
    res_found  = 1'b0;
    res_data   = '0;

    case (state_r)
      ole_pkg::S_IDLE: begin
        // head read issued now, data ready next cycle
        if (in_ch.valid) begin
          op_nxt   = ole_pkg::ole_op_t'(in_ch.op);
          val_nxt  = in_ch.value;
          p_nxt    = head_r;
          prev_nxt = head_r;
          idx_nxt  = '0;
          if (in_ch.op inside {ole_pkg::OP_SEARCH, ole_pkg::OP_REM_VAL}) begin
            state_nxt = ole_pkg::S_WALK;
          end else begin
            state_nxt = ole_pkg::S_EXEC;
          end
        end
      end

      ole_pkg::S_EXEC: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ole_pkg::S_IDLE;
          case (op_r)
            ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL: begin
              if (cnt_r == CW'(DEPTH)) begin
                res_status = ole_pkg::STAT_FULL;
              end else begin
                v_we     = 1'b1;
                ftop_nxt = ftop_m1;
                if (ftop_m1 < lw_r) begin
                  lw_nxt = ftop_m1;
                end
                if (cnt_r == '0) begin
                  head_nxt = alloc_slot;
                  tail_nxt = alloc_slot;
                end else if (op_r == ole_pkg::OP_INS_HEAD) begin
                  l_we     = 1'b1;
                  head_nxt = alloc_slot;
                end else begin
                  // tail link never read, so only the old tail is relinked
                  l_we     = 1'b1;
                  l_waddr  = tail_r;
                  l_wdata  = alloc_slot;
                  tail_nxt = alloc_slot;
                end
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            ole_pkg::OP_REM_HEAD: begin
              if (cnt_r == '0) begin
                res_status = ole_pkg::STAT_MISS;
              end else begin
                res_data = v_rd;
                f_we     = 1'b1;  // p_r holds head_r
                ftop_nxt = ftop_r + CW'(1);
                cnt_nxt  = cnt_r - CW'(1);
                if (cnt_r == CW'(1)) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  head_nxt = l_rd;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ole_pkg::S_WALK: begin
        rd_addr = p_r;  // hold read data while stalled
        if (walk_end) begin
          if (out_free) begin
            done       = 1'b1;
            res_status = ole_pkg::STAT_MISS;
            state_nxt  = ole_pkg::S_IDLE;
          end
        end else if (hit) begin
          if (out_free) begin
            done      = 1'b1;
            res_found = 1'b1;
            state_nxt = ole_pkg::S_IDLE;
            if (op_r == ole_pkg::OP_REM_VAL) begin
              f_we     = 1'b1;
              ftop_nxt = ftop_r + CW'(1);
              cnt_nxt  = cnt_r - CW'(1);
              if (idx_r == '0) begin
                head_nxt = l_rd;
              end else begin
                l_we    = 1'b1;
                l_waddr = prev_r;
                l_wdata = l_rd;
                if (idx_r + CW'(1) == cnt_r) begin
                  tail_nxt = prev_r;
                end
              end
              if (cnt_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end
            end
          end
        end else begin
          // follow the link; next entry read this cycle
          rd_addr  = l_rd;
          p_nxt    = l_rd;
          prev_nxt = p_r;
          idx_nxt  = idx_r + CW'(1);
        end
      end

      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      cnt_r       <= '0;
      ftop_r      <= CW'(DEPTH);
      lw_r        <= CW'(DEPTH);
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ftop_r  <= ftop_nxt;
      lw_r    <= lw_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    p_r    <= p_nxt;
    prev_r <= prev_nxt;
    idx_r  <= idx_nxt;
    if (done) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_data_r   <= res_data;
      out_count_r  <= cnt_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.count  = out_count_r;

endmodule
`default_nettype wire
